// File: rtl/tgac_pkg.sv
// Package for the take-grant access check block.
// Field widths, rights bit positions, request kinds and the control/status
// structs shared by the core modules. No dependencies.
package tgac_pkg;

  localparam int NODES_DEF    = 8;
  localparam int NODE_FIELD_W = 3;
  localparam int RIGHTS_W     = 6;

  // rights bits: o,i,w,r,t,g from bit 0 up
  localparam int RIGHT_T_BIT = 4;
  localparam int RIGHT_G_BIT = 5;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // top -> engine
  typedef struct packed {
    logic start;  // item accepted this cycle
    logic ack;    // result moved into the output register
  } tgac_ctl_t;

  // engine -> top
  typedef struct packed {
    logic idle;     // can take an item
    logic done;     // result ready for the output register
    logic granted;
  } tgac_stat_t;

endpackage

// File: rtl/tgac_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on tgac_pkg.
interface tgac_req_if import tgac_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [NODE_FIELD_W-1:0] row_node;
  logic [NODE_FIELD_W-1:0] col_node;
  logic [RIGHTS_W-1:0]     entry_rights;
  logic [NODE_FIELD_W-1:0] source_node;
  logic [RIGHTS_W-1:0]     requested_rights;

  modport source (output valid, req_type, row_node, col_node, entry_rights,
                  source_node, requested_rights, input ready);
  modport sink   (input valid, req_type, row_node, col_node, entry_rights,
                  source_node, requested_rights, output ready);
endinterface

interface tgac_rsp_if;
  logic valid;
  logic ready;
  logic granted;

  modport source (output valid, granted, input ready);
  modport sink   (input valid, granted, output ready);
endinterface

// File: rtl/tgac_matrix.sv
// Rights matrix storage: NODES*NODES entries, one write and one registered
// read port, with a clearing sweep after reset. Depends on tgac_pkg.
module tgac_matrix import tgac_pkg::*; #(
  parameter int NODES = NODES_DEF,
  localparam int AW = $clog2(NODES * NODES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [RIGHTS_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [RIGHTS_W-1:0] rdata_o,
  output logic                clearing_o
);

  localparam int DEPTH = NODES * NODES;

  logic [RIGHTS_W-1:0] mem_q [DEPTH];
  logic [RIGHTS_W-1:0] rdata_q;
  logic [AW-1:0]       clr_q, clr_d;
  logic                clearing_q, clearing_d;

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      if (clr_q == AW'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_d = clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_q      <= clr_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_q] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

// File: rtl/tgac_engine.sv
// Sequencer and entry check unit: handles writes and runs the closure
// passes over the matrix for queries. Depends on tgac_pkg, tgac_matrix ports.
module tgac_engine import tgac_pkg::*; #(
  parameter int NODES = NODES_DEF,
  localparam int AW = $clog2(NODES * NODES),
  localparam int NW = $clog2(NODES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tgac_ctl_t               ctl_i,
  input  logic                    req_type_i,
  input  logic [NODE_FIELD_W-1:0] row_node_i,
  input  logic [NODE_FIELD_W-1:0] col_node_i,
  input  logic [RIGHTS_W-1:0]     entry_rights_i,
  input  logic [NODE_FIELD_W-1:0] source_node_i,
  input  logic [RIGHTS_W-1:0]     requested_rights_i,
  output tgac_stat_t              stat_o,
  input  logic                    clearing_i,
  output logic                    mem_we_o,
  output logic [AW-1:0]           mem_waddr_o,
  output logic [RIGHTS_W-1:0]     mem_wdata_o,
  output logic                    mem_re_o,
  output logic [AW-1:0]           mem_raddr_o,
  input  logic [RIGHTS_W-1:0]     mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [NODES-1:0]    set_q, set_d;
  logic [RIGHTS_W-1:0] held_q, held_d;
  logic [RIGHTS_W-1:0] req_q, req_d;
  logic                changed_q, changed_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic [NW-1:0]       row_q, row_d, col_q, col_d;
  logic                issue_q, issue_d;
  logic                rv_q, rv_d, rlast_q, rlast_d;
  logic [NW-1:0]       rrow_q, rrow_d, rcol_q, rcol_d;
  logic                granted_q, granted_d;

  logic                wr_ok, src_ok, last_addr;
  logic                tg, in_r, in_c, hit, new_change;
  logic [NODES-1:0]    set_hit;
  logic [RIGHTS_W-1:0] held_nxt;

  assign wr_ok = ctl_i.start && (req_type_i == REQ_WRITE) &&
                 (int'(row_node_i) < NODES) && (int'(col_node_i) < NODES);
  assign src_ok = int'(source_node_i) < NODES;

  assign mem_we_o    = wr_ok;
  assign mem_waddr_o = AW'(int'(row_node_i) * NODES + int'(col_node_i));
  assign mem_wdata_o = entry_rights_i;
  assign mem_re_o    = issue_q;
  assign mem_raddr_o = addr_q;

  assign last_addr = addr_q == AW'(NODES * NODES - 1);

  // entry check unit: one matrix entry per cycle against the current set
  assign tg   = mem_rdata_i[RIGHT_T_BIT] | mem_rdata_i[RIGHT_G_BIT];
  assign in_r = set_q[rrow_q];
  assign in_c = set_q[rcol_q];
  assign hit  = rv_q && tg && (in_r || in_c);
  assign set_hit = hit ? (set_q | (NODES'(1) << rrow_q) | (NODES'(1) << rcol_q)) : set_q;
  assign new_change = set_hit != set_q;
  assign held_nxt = (rv_q && in_r) ? (held_q | mem_rdata_i) : held_q;

  always_comb begin
    state_d   = state_q;
    set_d     = set_q;
    held_d    = held_q;
    req_d     = req_q;
    changed_d = changed_q;
    addr_d    = addr_q;
    row_d     = row_q;
    col_d     = col_q;
    issue_d   = issue_q;
    rv_d      = 1'b0;
    rlast_d   = rlast_q;
    rrow_d    = rrow_q;
    rcol_d    = rcol_q;
    granted_d = granted_q;

    case (state_q)
      S_IDLE: begin
        if (ctl_i.start && !clearing_i) begin
          if (req_type_i == REQ_WRITE) begin
            granted_d = 1'b0;
            state_d   = S_DONE;
          end else begin
            set_d     = src_ok ? (NODES'(1) << source_node_i) : '0;
            req_d     = requested_rights_i;
            held_d    = '0;
            changed_d = 1'b0;
            addr_d    = '0;
            row_d     = '0;
            col_d     = '0;
            issue_d   = 1'b1;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue_q) begin
          rv_d    = 1'b1;
          rrow_d  = row_q;
          rcol_d  = col_q;
          rlast_d = last_addr;
          if (last_addr) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q + AW'(1);
            if (col_q == NW'(NODES - 1)) begin
              col_d = '0;
              row_d = row_q + NW'(1);
            end else begin
              col_d = col_q + NW'(1);
            end
          end
        end
        if (rv_q) begin
          set_d     = set_hit;
          held_d    = held_nxt;
          changed_d = changed_q || new_change;
          if (rlast_q) begin
            if (changed_q || new_change) begin
              // set grew this pass: sweep again
              changed_d = 1'b0;
              held_d    = '0;
              addr_d    = '0;
              row_d     = '0;
              col_d     = '0;
              issue_d   = 1'b1;
            end else begin
              granted_d = (req_q & ~held_nxt) == '0;
              state_d   = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (ctl_i.ack) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      issue_q <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q     <= set_d;
    held_q    <= held_d;
    req_q     <= req_d;
    changed_q <= changed_d;
    addr_q    <= addr_d;
    row_q     <= row_d;
    col_q     <= col_d;
    rlast_q   <= rlast_d;
    rrow_q    <= rrow_d;
    rcol_q    <= rcol_d;
    granted_q <= granted_d;
  end

  assign stat_o.idle    = (state_q == S_IDLE) && !clearing_i;
  assign stat_o.done    = state_q == S_DONE;
  assign stat_o.granted = granted_q;

`ifndef ASSERT_OFF
  // reachable set only grows during a query
  a_set_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && $past(state_q) == S_SCAN) |->
      ((set_q & $past(set_q)) == $past(set_q)))
    else $error("reach set lost a node during a query");

  // a write item answers with a refusal right away
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && ctl_i.start && !clearing_i && req_type_i == REQ_WRITE)
      |=> (state_q == S_DONE && !granted_q))
    else $error("write item did not give granted = 0");

  // matrix writes only come from an accepted write item
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_IDLE && !clearing_i))
    else $error("matrix write outside idle");

  // no reads issued outside a query sweep
  a_read_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re_o |-> (state_q == S_SCAN))
    else $error("matrix read outside a sweep");
`endif

endmodule

// File: rtl/take_grant_access_check_core.sv
// Take-grant access check core: top level with handshakes and result register.
// Depends on tgac_pkg, tgac_if, tgac_matrix, tgac_engine.

// The block holds a NODES x NODES matrix of 6-bit rights sets (o,i,w,r,t,g
// from bit 0). A write item stores one entry (ignored when out of range) and
// returns granted = 0 without a sweep. A query item finds every node joined
// to source_node by take or grant edges in either direction and returns
// granted = 1 when each requested right appears in the row of some node of
// that set. The block takes one item at a time. A query sweeps the matrix
// through its single read port, one entry per cycle, repeating the sweep
// until the set stops growing, for between 1 and NODES sweeps. After reset a
// clearing sweep over all NODES*NODES entries runs before the first item is
// taken. A result waits in an output register, so the next item can be
// taken while it is still pending.
module take_grant_access_check_core import tgac_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgac_req_if.sink   req_i,
  tgac_rsp_if.source rsp_o
);

  localparam int AW = $clog2(NODES * NODES);

  tgac_ctl_t           ctl;
  tgac_stat_t          stat;
  logic                out_valid_q, out_granted_q;
  logic                load;
  logic                mem_we, mem_re, clearing;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [RIGHTS_W-1:0] mem_wdata, mem_rdata;

  assign req_i.ready = stat.idle;
  assign load        = stat.done && (!out_valid_q || rsp_o.ready);
  assign ctl.start   = req_i.valid && req_i.ready;
  assign ctl.ack     = load;

  tgac_engine #(.NODES(NODES)) u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .req_type_i         (req_i.req_type),
    .row_node_i         (req_i.row_node),
    .col_node_i         (req_i.col_node),
    .entry_rights_i     (req_i.entry_rights),
    .source_node_i      (req_i.source_node),
    .requested_rights_i (req_i.requested_rights),
    .stat_o             (stat),
    .clearing_i         (clearing),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_re_o           (mem_re),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata)
  );

  tgac_matrix #(.NODES(NODES)) u_matrix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (mem_we),
    .waddr_i    (mem_waddr),
    .wdata_i    (mem_wdata),
    .re_i       (mem_re),
    .raddr_i    (mem_raddr),
    .rdata_o    (mem_rdata),
    .clearing_o (clearing)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_granted_q <= stat.granted;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.granted = out_granted_q;

endmodule
